/* rtl/factor_verify_with_prime_test_macros.svh */
// Assertion helpers. Each expects clk and rst to be visible where it is used.
`ifndef FACTOR_VERIFY_WITH_PRIME_TEST_MACROS_SVH
`define FACTOR_VERIFY_WITH_PRIME_TEST_MACROS_SVH

// The consequent holds in the same cycle as the trigger.
`define FVP_IMPLY(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the trigger.
`define FVP_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/fvp_pkg.sv */
`timescale 1ns / 1ps
package fvp_pkg;

  localparam int DEF_NUM_WITNESSES = 7;
  localparam int DEF_EXP_BITS      = 32;

  localparam logic [63:0] TOP_BIT = 64'h8000000000000000;

  // Datapath operations.
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_INV_INIT   = 5'd1;
  localparam logic [4:0] OP_INV_STEP   = 5'd2;
  localparam logic [4:0] OP_RMOD       = 5'd3;
  localparam logic [4:0] OP_ACC_ONE    = 5'd4;
  localparam logic [4:0] OP_DBL        = 5'd5;
  localparam logic [4:0] OP_MONT       = 5'd6;
  localparam logic [4:0] OP_SET_R2     = 5'd7;
  localparam logic [4:0] OP_DECOMP     = 5'd8;
  localparam logic [4:0] OP_TOP        = 5'd9;
  localparam logic [4:0] OP_WI_INIT    = 5'd10;
  localparam logic [4:0] OP_WI_INC     = 5'd11;
  localparam logic [4:0] OP_WMOD       = 5'd12;
  localparam logic [4:0] OP_MASK_INIT  = 5'd13;
  localparam logic [4:0] OP_MASK_SHIFT = 5'd14;
  localparam logic [4:0] OP_SC_INIT    = 5'd15;
  localparam logic [4:0] OP_SC_INC     = 5'd16;
  localparam logic [4:0] OP_LOADN      = 5'd17;

  // Montgomery operand and destination selects.
  localparam logic [1:0] A_ACC  = 2'd0;
  localparam logic [1:0] A_WIT  = 2'd1;
  localparam logic [1:0] A_BASE = 2'd2;
  localparam logic [1:0] A_MULT = 2'd3;
  localparam logic [1:0] B_ACC  = 2'd0;
  localparam logic [1:0] B_R2   = 2'd1;
  localparam logic [1:0] B_MW   = 2'd2;
  localparam logic [1:0] D_ACC  = 2'd0;
  localparam logic [1:0] D_MW   = 2'd1;
  localparam logic [1:0] D_BOTH = 2'd2;

  localparam logic [1:0] VERDICT_NOT       = 2'd0;
  localparam logic [1:0] VERDICT_FACTOR    = 2'd1;
  localparam logic [1:0] VERDICT_COMPOSITE = 2'd2;

  typedef struct packed {
    logic       take;
    logic       start;
    logic [4:0] op;
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic [1:0] dst;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic bad;
    logic expo_zero;
    logic w_zero;
    logic exp_bit;
    logic mask_zero;
    logic acc_one;
    logic acc_mone;
    logic sc_lt;
    logic wi_last;
    logic hit;
  } stat_t;

  function automatic logic [31:0] witness(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0: w = 32'd2;
      3'd1: w = 32'd325;
      3'd2: w = 32'd9375;
      3'd3: w = 32'd28178;
      3'd4: w = 32'd450775;
      3'd5: w = 32'd9780504;
      3'd6: w = 32'd1795265022;
      default: w = 32'd2;
    endcase
    return w;
  endfunction

endpackage

/* rtl/fvp_if.sv */
`timescale 1ns / 1ps
interface fvp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] candidate;
  logic [63:0] multiplier;
  logic [31:0] power;
  modport source (output valid, candidate, multiplier, power, input ready);
  modport sink (input valid, candidate, multiplier, power, output ready);
endinterface

interface fvp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

/* rtl/fvp_mul.sv */
`timescale 1ns / 1ps
module fvp_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [1:0]  idx;
  logic        busy;
  logic        pv;
  logic        plast;
  logic [1:0]  psh;
  logic [63:0] pp;
  logic [31:0] a_part;
  logic [31:0] b_part;
  logic [127:0] pp_shift;

  assign a_part   = idx[0] ? a_q[63:32] : a_q[31:0];
  assign b_part   = idx[1] ? b_q[63:32] : b_q[31:0];
  assign pp_shift = {64'b0, pp} << {psh, 5'b0};

  // One 32x32 partial product per cycle, accumulated in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pv    <= 1'b0;
      plast <= 1'b0;
      done  <= 1'b0;
    end else begin
      done  <= !start && pv && plast;
      pv    <= busy && !start;
      plast <= (idx == 2'd3);
      if (start) begin
        a_q  <= a;
        b_q  <= b;
        idx  <= 2'd0;
        busy <= 1'b1;
        prod <= '0;
      end else begin
        if (busy) begin
          pp  <= 64'(a_part) * 64'(b_part);
          psh <= {1'b0, idx[0]} + {1'b0, idx[1]};
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            busy <= 1'b0;
          end
        end
        if (pv) begin
          prod <= prod + pp_shift;
        end
      end
    end
  end

endmodule

/* rtl/fvp_datapath.sv */
`timescale 1ns / 1ps
module fvp_datapath #(
  parameter int NUM_WITNESSES = fvp_pkg::DEF_NUM_WITNESSES,
  parameter int EXP_BITS      = fvp_pkg::DEF_EXP_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  fvp_pkg::cmd_t cmd,
  output fvp_pkg::stat_t st,
  input  logic [63:0]   candidate,
  input  logic [63:0]   multiplier,
  input  logic [31:0]   power,
  input  logic [31:0]   number_base,
  input  logic          sign_plus
);

  localparam logic [63:0] EMASK = (EXP_BITS >= 64) ? {64{1'b1}} :
                                  ((64'd1 << EXP_BITS) - 64'd1);

  localparam logic [3:0] DS_IDLE   = 4'd0;
  localparam logic [3:0] DS_NEW1   = 4'd1;
  localparam logic [3:0] DS_NEW2   = 4'd2;
  localparam logic [3:0] DS_MUL1   = 4'd3;
  localparam logic [3:0] DS_MUL2   = 4'd4;
  localparam logic [3:0] DS_MUL3   = 4'd5;
  localparam logic [3:0] DS_RMOD   = 4'd6;
  localparam logic [3:0] DS_MONE   = 4'd7;
  localparam logic [3:0] DS_WMOD   = 4'd8;
  localparam logic [3:0] DS_DECOMP = 4'd9;
  localparam logic [3:0] DS_TOP    = 4'd10;

  logic [3:0]  ds;
  logic        done_q;
  logic [63:0] p, k, inv, one, mone, r2, acc, mw, w, expo, top, mask, rem, h;
  logic [31:0] n, wsrc;
  logic [6:0]  tcnt, scnt;
  logic [2:0]  wi;
  logic [5:0]  cnt;
  logic [1:0]  dst_q;

  logic         mul_start;
  logic [63:0]  mul_a, mul_b;
  logic         mul_done;
  logic [127:0] mul_prod;

  logic [63:0] a_val, b_val, dbl_val, mres, mh;
  logic [64:0] rmod_d, wmod_d, p_ext;
  logic [63:0] rmod_n, wmod_n;

  fvp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    case (cmd.a_sel)
      fvp_pkg::A_ACC:  a_val = acc;
      fvp_pkg::A_WIT:  a_val = w;
      fvp_pkg::A_BASE: a_val = {32'b0, number_base};
      fvp_pkg::A_MULT: a_val = k;
      default:         a_val = acc;
    endcase
    case (cmd.b_sel)
      fvp_pkg::B_ACC: b_val = acc;
      fvp_pkg::B_R2:  b_val = r2;
      fvp_pkg::B_MW:  b_val = mw;
      default:        b_val = acc;
    endcase
  end

  // Modular doubling of the accumulator.
  assign dbl_val = acc + acc - ((acc >= p - acc) ? p : 64'd0);

  assign p_ext  = {1'b0, p};
  assign rmod_d = {rem, 1'b0};
  assign rmod_n = (rmod_d >= p_ext) ? 64'(rmod_d - p_ext) : rmod_d[63:0];
  assign wmod_d = {rem, wsrc[31]};
  assign wmod_n = (wmod_d >= p_ext) ? 64'(wmod_d - p_ext) : wmod_d[63:0];

  assign mh   = mul_prod[127:64];
  assign mres = h - mh + ((h < mh) ? p : 64'd0);

  always_comb begin
    st.done      = done_q;
    st.bad       = !p[0] || (p < 64'd3);
    st.expo_zero = (expo == 64'd0);
    st.w_zero    = (w == 64'd0);
    st.exp_bit   = |(expo & mask);
    st.mask_zero = (mask == 64'd0);
    st.acc_one   = (acc == one);
    st.acc_mone  = (acc == mone);
    st.sc_lt     = (scnt < tcnt);
    st.wi_last   = (wi == 3'(NUM_WITNESSES - 1));
    st.hit       = sign_plus ? (acc == mone) : (acc == one);
  end

  always_ff @(posedge clk) begin : dp_seq
    logic done_next;
    logic mul_start_next;
    if (rst) begin
      ds        <= DS_IDLE;
      done_q    <= 1'b0;
      mul_start <= 1'b0;
    end else begin
      done_next      = 1'b0;
      mul_start_next = 1'b0;
      if (cmd.take) begin
        p <= candidate;
        k <= multiplier;
        n <= power;
      end
      case (ds)
        DS_IDLE: begin
          if (cmd.start) begin
            case (cmd.op)
              fvp_pkg::OP_INV_INIT: begin
                inv       <= 64'd1;
                done_next = 1'b1;
              end
              fvp_pkg::OP_INV_STEP: begin
                mul_a          <= p;
                mul_b          <= inv;
                mul_start_next = 1'b1;
                ds             <= DS_NEW1;
              end
              fvp_pkg::OP_RMOD: begin
                rem <= 64'd1;
                cnt <= 6'd0;
                ds  <= DS_RMOD;
              end
              fvp_pkg::OP_ACC_ONE: begin
                acc       <= one;
                done_next = 1'b1;
              end
              fvp_pkg::OP_DBL: begin
                acc       <= dbl_val;
                done_next = 1'b1;
              end
              fvp_pkg::OP_MONT: begin
                mul_a          <= a_val;
                mul_b          <= b_val;
                mul_start_next = 1'b1;
                dst_q          <= cmd.dst;
                ds             <= DS_MUL1;
              end
              fvp_pkg::OP_SET_R2: begin
                r2        <= acc;
                done_next = 1'b1;
              end
              fvp_pkg::OP_DECOMP: begin
                expo <= p - 64'd1;
                tcnt <= 7'd0;
                ds   <= DS_DECOMP;
              end
              fvp_pkg::OP_TOP: begin
                top <= fvp_pkg::TOP_BIT;
                ds  <= DS_TOP;
              end
              fvp_pkg::OP_WI_INIT: begin
                wi        <= 3'd0;
                done_next = 1'b1;
              end
              fvp_pkg::OP_WI_INC: begin
                wi        <= wi + 3'd1;
                done_next = 1'b1;
              end
              fvp_pkg::OP_WMOD: begin
                wsrc <= fvp_pkg::witness(wi);
                rem  <= 64'd0;
                cnt  <= 6'd0;
                ds   <= DS_WMOD;
              end
              fvp_pkg::OP_MASK_INIT: begin
                mask      <= top >> 1;
                done_next = 1'b1;
              end
              fvp_pkg::OP_MASK_SHIFT: begin
                mask      <= mask >> 1;
                done_next = 1'b1;
              end
              fvp_pkg::OP_SC_INIT: begin
                scnt      <= 7'd1;
                done_next = 1'b1;
              end
              fvp_pkg::OP_SC_INC: begin
                scnt      <= scnt + 7'd1;
                done_next = 1'b1;
              end
              fvp_pkg::OP_LOADN: begin
                expo      <= {32'b0, n} & EMASK;
                done_next = 1'b1;
              end
              default: begin
                done_next = 1'b1;
              end
            endcase
          end
        end
        DS_NEW1: begin
          if (mul_done) begin
            mul_a          <= inv;
            mul_b          <= 64'd2 - mul_prod[63:0];
            mul_start_next = 1'b1;
            ds             <= DS_NEW2;
          end
        end
        DS_NEW2: begin
          if (mul_done) begin
            inv       <= mul_prod[63:0];
            done_next = 1'b1;
            ds        <= DS_IDLE;
          end
        end
        DS_MUL1: begin
          if (mul_done) begin
            h              <= mul_prod[127:64];
            mul_a          <= mul_prod[63:0];
            mul_b          <= inv;
            mul_start_next = 1'b1;
            ds             <= DS_MUL2;
          end
        end
        DS_MUL2: begin
          if (mul_done) begin
            mul_a          <= mul_prod[63:0];
            mul_b          <= p;
            mul_start_next = 1'b1;
            ds             <= DS_MUL3;
          end
        end
        DS_MUL3: begin
          if (mul_done) begin
            case (dst_q)
              fvp_pkg::D_ACC: acc <= mres;
              fvp_pkg::D_MW:  mw <= mres;
              default: begin
                acc <= mres;
                mw  <= mres;
              end
            endcase
            done_next = 1'b1;
            ds        <= DS_IDLE;
          end
        end
        DS_RMOD: begin
          // Sixty-four modular doublings of one give R mod p.
          cnt <= cnt + 6'd1;
          rem <= rmod_n;
          if (cnt == 6'd63) begin
            one <= rmod_n;
            ds  <= DS_MONE;
          end
        end
        DS_MONE: begin
          mone      <= p - one;
          done_next = 1'b1;
          ds        <= DS_IDLE;
        end
        DS_WMOD: begin
          cnt  <= cnt + 6'd1;
          rem  <= wmod_n;
          wsrc <= wsrc << 1;
          if (cnt == 6'd31) begin
            w         <= wmod_n;
            done_next = 1'b1;
            ds        <= DS_IDLE;
          end
        end
        DS_DECOMP: begin
          if (!expo[0] && (tcnt < 7'd64)) begin
            expo <= expo >> 1;
            tcnt <= tcnt + 7'd1;
          end else begin
            done_next = 1'b1;
            ds        <= DS_IDLE;
          end
        end
        DS_TOP: begin
          if ((expo & top) == 64'd0) begin
            top <= top >> 1;
          end else begin
            done_next = 1'b1;
            ds        <= DS_IDLE;
          end
        end
        default: begin
          ds <= DS_IDLE;
        end
      endcase
      done_q    <= done_next;
      mul_start <= mul_start_next;
    end
  end

endmodule

/* rtl/fvp_ctrl.sv */
`timescale 1ns / 1ps
module fvp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     verdict,
  output fvp_pkg::cmd_t  cmd,
  input  fvp_pkg::stat_t st
);

  localparam logic [5:0] S_IDLE     = 6'd0;
  localparam logic [5:0] S_CHK      = 6'd1;
  localparam logic [5:0] S_INV_INIT = 6'd2;
  localparam logic [5:0] S_INV      = 6'd3;
  localparam logic [5:0] S_RMOD     = 6'd4;
  localparam logic [5:0] S_ACC1     = 6'd5;
  localparam logic [5:0] S_DBL      = 6'd6;
  localparam logic [5:0] S_R2SQ     = 6'd7;
  localparam logic [5:0] S_SETR2    = 6'd8;
  localparam logic [5:0] S_DECOMP   = 6'd9;
  localparam logic [5:0] S_TOP      = 6'd10;
  localparam logic [5:0] S_WI_INIT  = 6'd11;
  localparam logic [5:0] S_WMOD     = 6'd12;
  localparam logic [5:0] S_WZCHK    = 6'd13;
  localparam logic [5:0] S_MASK     = 6'd14;
  localparam logic [5:0] S_MONTW    = 6'd15;
  localparam logic [5:0] S_LOOP     = 6'd16;
  localparam logic [5:0] S_SQ       = 6'd17;
  localparam logic [5:0] S_BIT      = 6'd18;
  localparam logic [5:0] S_MULB     = 6'd19;
  localparam logic [5:0] S_SHIFT    = 6'd20;
  localparam logic [5:0] S_WCHK     = 6'd21;
  localparam logic [5:0] S_SCINIT   = 6'd22;
  localparam logic [5:0] S_SCLOOP   = 6'd23;
  localparam logic [5:0] S_SQ2      = 6'd24;
  localparam logic [5:0] S_SCCHK    = 6'd25;
  localparam logic [5:0] S_SCINC    = 6'd26;
  localparam logic [5:0] S_WNEXT    = 6'd27;
  localparam logic [5:0] S_WIINC    = 6'd28;
  localparam logic [5:0] S_LOADN    = 6'd29;
  localparam logic [5:0] S_NCHK     = 6'd30;
  localparam logic [5:0] S_MBASE    = 6'd31;
  localparam logic [5:0] S_ACCONE_N = 6'd32;
  localparam logic [5:0] S_KM       = 6'd33;
  localparam logic [5:0] S_FINAL    = 6'd34;
  localparam logic [5:0] S_FIN      = 6'd35;

  logic [5:0] state;
  logic       issued;
  logic [2:0] cnt;
  logic       exp_ph;
  logic [1:0] verdict_q;
  logic       is_op;
  logic [4:0] op;
  logic [1:0] a_sel, b_sel, dst;
  logic       fin_fire;

  always_comb begin
    is_op = 1'b1;
    op    = fvp_pkg::OP_MONT;
    a_sel = fvp_pkg::A_ACC;
    b_sel = fvp_pkg::B_ACC;
    dst   = fvp_pkg::D_ACC;
    case (state)
      S_INV_INIT: op = fvp_pkg::OP_INV_INIT;
      S_INV:      op = fvp_pkg::OP_INV_STEP;
      S_RMOD:     op = fvp_pkg::OP_RMOD;
      S_ACC1:     op = fvp_pkg::OP_ACC_ONE;
      S_DBL:      op = fvp_pkg::OP_DBL;
      S_R2SQ, S_SQ, S_SQ2: op = fvp_pkg::OP_MONT;
      S_SETR2:    op = fvp_pkg::OP_SET_R2;
      S_DECOMP:   op = fvp_pkg::OP_DECOMP;
      S_TOP:      op = fvp_pkg::OP_TOP;
      S_WI_INIT:  op = fvp_pkg::OP_WI_INIT;
      S_WMOD:     op = fvp_pkg::OP_WMOD;
      S_MASK:     op = fvp_pkg::OP_MASK_INIT;
      S_MONTW: begin
        a_sel = fvp_pkg::A_WIT;
        b_sel = fvp_pkg::B_R2;
        dst   = fvp_pkg::D_BOTH;
      end
      S_MULB:     b_sel = fvp_pkg::B_MW;
      S_SHIFT:    op = fvp_pkg::OP_MASK_SHIFT;
      S_SCINIT:   op = fvp_pkg::OP_SC_INIT;
      S_SCINC:    op = fvp_pkg::OP_SC_INC;
      S_WIINC:    op = fvp_pkg::OP_WI_INC;
      S_LOADN:    op = fvp_pkg::OP_LOADN;
      S_MBASE: begin
        a_sel = fvp_pkg::A_BASE;
        b_sel = fvp_pkg::B_R2;
        dst   = fvp_pkg::D_BOTH;
      end
      S_ACCONE_N: op = fvp_pkg::OP_ACC_ONE;
      S_KM: begin
        a_sel = fvp_pkg::A_MULT;
        b_sel = fvp_pkg::B_R2;
        dst   = fvp_pkg::D_MW;
      end
      S_FINAL:    b_sel = fvp_pkg::B_MW;
      default: begin
        is_op = 1'b0;
        op    = fvp_pkg::OP_NONE;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign cmd.take  = in_ready && in_valid;
  assign cmd.start = is_op && !issued;
  assign cmd.op    = op;
  assign cmd.a_sel = a_sel;
  assign cmd.b_sel = b_sel;
  assign cmd.dst   = dst;

  // The verdict register is free once its word leaves in this cycle.
  assign fin_fire = (state == S_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      exp_ph    <= 1'b0;
      cnt       <= 3'd0;
    end else begin
      out_valid <= fin_fire || (out_valid && !out_ready);
      issued    <= !(is_op && st.done) && (issued || cmd.start);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state  <= S_CHK;
            exp_ph <= 1'b0;
          end
        end
        S_CHK: begin
          if (st.bad) begin
            verdict_q <= fvp_pkg::VERDICT_COMPOSITE;
            state     <= S_FIN;
          end else begin
            state <= S_INV_INIT;
          end
        end
        S_INV_INIT: if (st.done) begin
          cnt   <= 3'd0;
          state <= S_INV;
        end
        S_INV: if (st.done) begin
          // Seven Newton steps give the inverse modulo 2^64.
          cnt <= cnt + 3'd1;
          if (cnt == 3'd6) begin
            state <= S_RMOD;
          end
        end
        S_RMOD: if (st.done) state <= S_ACC1;
        S_ACC1: if (st.done) begin
          cnt   <= 3'd0;
          state <= S_DBL;
        end
        S_DBL: if (st.done) begin
          if (cnt == 3'd1) begin
            cnt   <= 3'd0;
            state <= S_R2SQ;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_R2SQ: if (st.done) begin
          // Five squarings of 4R reach R^2 mod p.
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= S_SETR2;
          end
        end
        S_SETR2:   if (st.done) state <= S_DECOMP;
        S_DECOMP:  if (st.done) state <= S_TOP;
        S_TOP:     if (st.done) state <= exp_ph ? S_MASK : S_WI_INIT;
        S_WI_INIT: if (st.done) state <= S_WMOD;
        S_WMOD:    if (st.done) state <= S_WZCHK;
        S_WZCHK:   state <= st.w_zero ? S_WNEXT : S_MASK;
        S_MASK:    if (st.done) state <= exp_ph ? S_LOOP : S_MONTW;
        S_MONTW:   if (st.done) state <= S_LOOP;
        S_LOOP: begin
          if (st.mask_zero) begin
            state <= exp_ph ? S_KM : S_WCHK;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ:    if (st.done) state <= S_BIT;
        S_BIT:   state <= st.exp_bit ? S_MULB : S_SHIFT;
        S_MULB:  if (st.done) state <= S_SHIFT;
        S_SHIFT: if (st.done) state <= S_LOOP;
        S_WCHK:  state <= (st.acc_one || st.acc_mone) ? S_WNEXT : S_SCINIT;
        S_SCINIT: if (st.done) state <= S_SCLOOP;
        S_SCLOOP: begin
          if (st.sc_lt) begin
            state <= S_SQ2;
          end else begin
            verdict_q <= fvp_pkg::VERDICT_COMPOSITE;
            state     <= S_FIN;
          end
        end
        S_SQ2:   if (st.done) state <= S_SCCHK;
        S_SCCHK: state <= st.acc_mone ? S_WNEXT : S_SCINC;
        S_SCINC: if (st.done) state <= S_SCLOOP;
        S_WNEXT: begin
          if (st.wi_last) begin
            exp_ph <= 1'b1;
            state  <= S_LOADN;
          end else begin
            state <= S_WIINC;
          end
        end
        S_WIINC:    if (st.done) state <= S_WMOD;
        S_LOADN:    if (st.done) state <= S_NCHK;
        S_NCHK:     state <= st.expo_zero ? S_ACCONE_N : S_MBASE;
        S_MBASE:    if (st.done) state <= S_TOP;
        S_ACCONE_N: if (st.done) state <= S_KM;
        S_KM:       if (st.done) state <= S_FINAL;
        S_FINAL: if (st.done) begin
          verdict_q <= st.hit ? fvp_pkg::VERDICT_FACTOR : fvp_pkg::VERDICT_NOT;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (fin_fire) begin
            verdict <= verdict_q;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/factor_verify_with_prime_test.sv */
`timescale 1ns / 1ps
// One word at a time: an even or below-three candidate goes straight to a composite verdict;
// otherwise a setup phase is followed by Montgomery products, each made of three chained
// 64-bit multiplies on one shared 32x32 multiplier. A new word is taken only once the last
// verdict has moved into the output register, where it waits while the next word is worked
// on; a later verdict waits until that register is free. rst clears control state,
// number_base to 2, sign_plus to 0.
`include "factor_verify_with_prime_test_macros.svh"
module factor_verify_with_prime_test #(
  parameter int NUM_WITNESSES = fvp_pkg::DEF_NUM_WITNESSES,
  parameter int EXP_BITS      = fvp_pkg::DEF_EXP_BITS
) (
  input  logic        clk,
  input  logic        rst,
  fvp_in_if.sink      items,
  fvp_out_if.source   results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]    number_base;
  logic           sign_plus;
  fvp_pkg::cmd_t  cmd;
  fvp_pkg::stat_t st;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'b0, sign_plus} : number_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= 32'd2;
      sign_plus   <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        sign_plus <= pwdata[0];
      end else begin
        number_base <= pwdata;
      end
    end
  end

  fvp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .verdict   (results.verdict),
    .cmd       (cmd),
    .st        (st)
  );

  fvp_datapath #(
    .NUM_WITNESSES (NUM_WITNESSES),
    .EXP_BITS      (EXP_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .candidate   (items.candidate),
    .multiplier  (items.multiplier),
    .power       (items.power),
    .number_base (number_base),
    .sign_plus   (sign_plus)
  );

  `FVP_IMPLY(a_verdict_code, results.valid, results.verdict <= fvp_pkg::VERDICT_COMPOSITE)
  `FVP_NEXT(a_busy_after_take, items.valid && items.ready, !items.ready)

endmodule
